### rtl/cst_pkg.sv
package cst_pkg;

   // Commands carried on the request channel.
   localparam logic [1:0] CMD_MEASURE = 2'd0;
   localparam logic [1:0] CMD_APPLY   = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   localparam logic [7:0] FULL_SCALE = 8'd255;

   // Depth of the queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Divider geometry: a 16-bit dividend over an 8-bit divisor.
   localparam int unsigned DVD_W = 16;
   localparam int unsigned DVS_W = 8;
   localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

   // One apply request as it waits for the back, with the statistics it saw.
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] luma;
      logic [7:0] luma_min;
      logic [7:0] luma_max;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

### rtl/contrast_stretch_rgb.sv
// With the back idle, an apply request takes four divisions before it is answered, one when
// its stretched luma is zero, and none when the statistics are flat or the luma is zero.
// Measure and clear requests complete in the cycle they are accepted. The back finishes one
// apply request before it takes another, held by the shared divider that resolves one
// quotient bit per cycle over four 16-bit divisions; measure and clear run at one a cycle
// while the queue has room. Reset: synchronous, active high; it empties the queue and puts
// the minimum at 255 and the maximum at 0.
module contrast_stretch_rgb
   import cst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_pixel_blue,
   input  logic [7:0] req_pixel_green,
   input  logic [7:0] req_pixel_red,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_blue,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_red
);

   // The front takes every request. A measure request updates the running luma minimum and
   // maximum at once, and a clear request restores them. An apply request is written into the
   // queue together with a copy of the statistics as they stand, so later measure requests
   // cannot disturb a stretch that is still waiting for the back.
   queue_status_type q_stat;
   queue_entry_type  q_wdata;
   queue_entry_type  q_rdata;
   logic             q_push;
   logic             q_pop;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   cst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_pixel_blue  (req_pixel_blue),
      .req_pixel_green (req_pixel_green),
      .req_pixel_red   (req_pixel_red),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_wdata         (q_wdata)
   );

   // A short queue decouples the two halves: the front keeps measuring while the back works.
   cst_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // The back works out the stretched luma and then scales each channel by it, using the one
   // divider for all four quotients. Its output register holds a finished request while the
   // next queue entry is already being worked on.
   cst_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_rdata       (q_rdata),
      .q_pop         (q_pop),
      .div_req       (div_req),
      .div_rsp       (div_rsp),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_green (rsp_out_green),
      .rsp_out_red   (rsp_out_red)
   );

   cst_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

`ifndef SYNTH
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("apply request written into a full queue");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue read while empty");

   a_div_not_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while a division is in progress");

   a_div_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> $past(div_rsp.busy))
      else $error("divider finished without having been busy");
`endif

endmodule

### rtl/cst_front.sv
module cst_front
   import cst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_pixel_blue,
   input  logic [7:0]       req_pixel_green,
   input  logic [7:0]       req_pixel_red,
   input  queue_status_type q_stat,
   output logic             q_push,
   output queue_entry_type  q_wdata
);

   // x / 3 for an 8-bit x, as a multiplication by 171 / 512.
   function automatic logic [7:0] div3(input logic [7:0] x);
      logic [15:0] p;
      p = {8'h00, x} * 16'd171;
      return {1'b0, p[15:9]};
   endfunction

   logic [7:0] luma;
   logic [7:0] luma_min_ff, luma_min_in;
   logic [7:0] luma_max_ff, luma_max_in;
   logic       accept;

   assign luma      = div3(req_pixel_blue) + div3(req_pixel_green) + div3(req_pixel_red);
   assign req_ready = ~q_stat.full;
   assign accept    = req_valid & req_ready;
   assign q_push    = accept & (req_cmd == CMD_APPLY);

   assign q_wdata.blue     = req_pixel_blue;
   assign q_wdata.green    = req_pixel_green;
   assign q_wdata.red      = req_pixel_red;
   assign q_wdata.luma     = luma;
   assign q_wdata.luma_min = luma_min_ff;
   assign q_wdata.luma_max = luma_max_ff;

   always_comb begin
      luma_min_in = luma_min_ff;
      luma_max_in = luma_max_ff;
      if (accept) begin
         case (req_cmd)
            CMD_MEASURE: begin
               if (luma < luma_min_ff) luma_min_in = luma;
               if (luma > luma_max_ff) luma_max_in = luma;
            end
            CMD_CLEAR: begin
               luma_min_in = FULL_SCALE;
               luma_max_in = 8'd0;
            end
            default: begin
               luma_min_in = luma_min_ff;
               luma_max_in = luma_max_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_min_ff <= FULL_SCALE;
         luma_max_ff <= 8'd0;
      end else begin
         luma_min_ff <= luma_min_in;
         luma_max_ff <= luma_max_in;
      end
   end

endmodule

### rtl/cst_queue.sv
module cst_queue
   import cst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  wdata,
   input  logic             pop,
   output queue_entry_type  rdata,
   output queue_status_type stat
);

   queue_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wptr_ff, wptr_in;
   logic [QUEUE_PTR_W-1:0] rptr_ff, rptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rdata      = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wdata;
   end

endmodule

### rtl/cst_div.sv
module cst_div
   import cst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   // Restoring division, one quotient bit per cycle.
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = dvd_ff;

endmodule

### rtl/cst_back.sv
module cst_back
   import cst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  queue_entry_type  q_rdata,
   output logic             q_pop,
   output div_req_type      div_req,
   input  div_rsp_type      div_rsp,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_red
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_SCALE = 6'b000100,
      ST_PREP  = 6'b001000,
      ST_CHAN  = 6'b010000,
      ST_WRITE = 6'b100000
   } back_state_type;

   back_state_type  state_ff, state_in;
   queue_entry_type ent_ff, ent_in;
   logic [7:0]      s_ff, s_in;
   logic [1:0]      chan_ff, chan_in;
   logic [7:0]      res_ff [3];
   logic [7:0]      res_in [3];
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_blue_ff, out_green_ff, out_red_ff;
   logic            out_load;
   logic [7:0]      lc;
   logic [7:0]      diff;
   logic [7:0]      ch;
   logic [7:0]      q_sat;

   always_comb begin
      lc = ent_ff.luma;
      if (lc < ent_ff.luma_min) lc = ent_ff.luma_min;
      if (lc > ent_ff.luma_max) lc = ent_ff.luma_max;
   end

   assign diff  = lc - ent_ff.luma_min;
   assign q_sat = (|div_rsp.quotient[DVD_W-1:8]) ? FULL_SCALE : div_rsp.quotient[7:0];

   always_comb begin
      case (chan_ff)
         2'd0:    ch = ent_ff.blue;
         2'd1:    ch = ent_ff.green;
         default: ch = ent_ff.red;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      s_in         = s_ff;
      chan_in      = chan_ff;
      res_in       = res_ff;
      q_pop        = 1'b0;
      out_load     = 1'b0;
      out_valid_in = out_valid_ff & ~rsp_ready;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               ent_in   = q_rdata;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_in[0] = ent_ff.blue;
            res_in[1] = ent_ff.green;
            res_in[2] = ent_ff.red;
            if (ent_ff.luma_max <= ent_ff.luma_min || ent_ff.luma == 8'd0) begin
               state_in = ST_WRITE;
            end else begin
               // 255 * diff as diff * 256 - diff.
               div_req.start    = 1'b1;
               div_req.dividend = {diff, 8'h00} - {8'h00, diff};
               div_req.divisor  = ent_ff.luma_max - ent_ff.luma_min;
               state_in         = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (div_rsp.done) begin
               s_in    = div_rsp.quotient[7:0];
               chan_in = 2'd0;
               if (div_rsp.quotient[7:0] == 8'd0) state_in = ST_WRITE;
               else state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            div_req.start    = 1'b1;
            div_req.dividend = {8'h00, ch} * {8'h00, s_ff};
            div_req.divisor  = ent_ff.luma;
            state_in         = ST_CHAN;
         end
         ST_CHAN: begin
            if (div_rsp.done) begin
               res_in[chan_ff] = q_sat;
               if (chan_ff == 2'd2) begin
                  state_in = ST_WRITE;
               end else begin
                  chan_in  = chan_ff + 2'd1;
                  state_in = ST_PREP;
               end
            end
         end
         ST_WRITE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         chan_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         chan_ff      <= chan_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      s_ff   <= s_in;
      res_ff <= res_in;
      if (out_load) begin
         out_blue_ff  <= res_ff[0];
         out_green_ff <= res_ff[1];
         out_red_ff   <= res_ff[2];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_red   = out_red_ff;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the RGB min-max contrast stretch. Requests are driven at the falling
// edge and both handshakes are sampled at the rising edge. Every accepted request goes through
// a local copy of the luma statistics, and each apply request leaves one expected pixel in a
// queue. The response monitor compares returned pixels, channel by channel, in order.
module testbench;
   import cst_pkg::*;

   // The fourth command code has no name in the package. The block must ignore it.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int unsigned CLOCK_HALF    = 2;
   localparam int unsigned RESET_CYCLES  = 9;
   localparam int unsigned RANDOM_ITEMS  = 450;
   localparam int unsigned DRAIN_CYCLES  = 120;
   localparam int unsigned CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   // One row of the directed table. Where fixed_valid is set, fixed_px is the pixel the block
   // must return and the predictor is not consulted for that row.
   typedef struct {
      logic [1:0] cmd;
      rgb_type    px;
      bit         fixed_valid;
      rgb_type    fixed_px;
   } directed_row_type;

   localparam int unsigned DIRECTED_ROWS = 24;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_cmd;
   logic [7:0] req_pixel_blue;
   logic [7:0] req_pixel_green;
   logic [7:0] req_pixel_red;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_red;

   // Local copy of the block's statistics, advanced at every accepted request.
   logic [7:0] stat_min;
   logic [7:0] stat_max;

   rgb_type expected_pixels[$];

   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned measure_count;
   int unsigned apply_count;
   int unsigned clear_count;
   int unsigned ignored_count;
   int unsigned pixel_count;
   int unsigned burst_left;

   contrast_stretch_rgb i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_pixel_blue (req_pixel_blue),
      .req_pixel_green(req_pixel_green),
      .req_pixel_red  (req_pixel_red),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_red    (rsp_out_red)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Luma is the sum of the three channels, each divided by three and truncated first.
   function automatic logic [7:0] pixel_luma(rgb_type px);
      int unsigned sum;
      sum = int'(px.blue) / 3 + int'(px.green) / 3 + int'(px.red) / 3;
      return sum[7:0];
   endfunction

   function automatic logic [7:0] scale_channel(logic [7:0] ch, int unsigned gain,
                                                int unsigned luma);
      int unsigned v;
      v = (int'(ch) * gain) / luma;
      return (v > 255) ? FULL_SCALE : v[7:0];
   endfunction

   // Predicts the pixel returned for an apply request against the given statistics.
   function automatic rgb_type stretch_pixel(rgb_type px, logic [7:0] lo, logic [7:0] hi);
      int unsigned luma;
      int unsigned clamped;
      int unsigned gain;
      rgb_type     res;
      res  = px;
      luma = pixel_luma(px);
      // Flat or empty statistics, and a black luma, leave the pixel untouched.
      if (hi > lo && luma != 0) begin
         clamped = luma;
         if (clamped < lo) begin
            clamped = lo;
         end
         if (clamped > hi) begin
            clamped = hi;
         end
         gain = (255 * (clamped - lo)) / (hi - lo);
         // A stretched luma of zero also passes the pixel through. Note that the division
         // uses the luma as measured, not the clamped one, so channels can saturate.
         if (gain != 0) begin
            res.blue  = scale_channel(px.blue,  gain, luma);
            res.green = scale_channel(px.green, gain, luma);
            res.red   = scale_channel(px.red,   gain, luma);
         end
      end
      return res;
   endfunction

   // Drives one request and waits for its acceptance, then advances the local statistics.
   // The sender works in bursts: when a burst is used up it may drop valid for a while.
   task automatic issue_request(input logic [1:0] cmd, input rgb_type px, input bit fixed_valid,
                                input rgb_type fixed_px);
      int unsigned gap;
      logic [7:0]  luma;
      if (burst_left == 0) begin
         // A quarter of bursts follow on with no idle cycle at all.
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 10);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_pixel_blue  <= px.blue;
      req_pixel_green <= px.green;
      req_pixel_red   <= px.red;
      do @(posedge clock); while (!req_ready);
      luma = pixel_luma(px);
      case (cmd)
         CMD_MEASURE: begin
            if (luma < stat_min) begin
               stat_min = luma;
            end
            if (luma > stat_max) begin
               stat_max = luma;
            end
            measure_count++;
         end
         CMD_CLEAR: begin
            stat_min = FULL_SCALE;
            stat_max = 8'd0;
            clear_count++;
         end
         CMD_APPLY: begin
            if (fixed_valid) begin
               expected_pixels = {expected_pixels, fixed_px};
            end else begin
               expected_pixels = {expected_pixels, stretch_pixel(px, stat_min, stat_max)};
            end
            apply_count++;
         end
         default: begin
            ignored_count++;
         end
      endcase
   endtask

   // Holds the sender back until every outstanding apply request has been answered.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Channel values are biased towards the ends of the range so that zero lumas and
   // saturation turn up often, but otherwise fall between the given bounds.
   function automatic logic [7:0] pick_channel(int unsigned lo, int unsigned hi);
      int unsigned roll;
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
         return 8'd0;
      end else if (roll == 1) begin
         return 8'd255;
      end
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic rgb_type pick_pixel(int unsigned lo, int unsigned hi);
      rgb_type px;
      px.blue  = pick_channel(lo, hi);
      px.green = pick_channel(lo, hi);
      px.red   = pick_channel(lo, hi);
      return px;
   endfunction

   // The receiver stalls on a pattern of its own: it switches at random between always ready,
   // a coin toss each cycle, and long holds broken by short open windows.
   int unsigned stall_mode;
   always @(negedge clock) begin
      if (cycle_count % 48 == 0) begin
         stall_mode <= $urandom_range(0, 2);
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= (cycle_count % 16) < 3;
      endcase
   end

   // Response monitor: each returned pixel is compared with the oldest expectation.
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: response with nothing expected: b=%0d g=%0d r=%0d",
                     $time, rsp_out_blue, rsp_out_green, rsp_out_red);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            pixel_count++;
            if (rsp_out_blue !== want.blue) begin
               $display("%0t: blue mismatch: expected %0d, actual %0d",
                        $time, want.blue, rsp_out_blue);
               error_count++;
            end
            if (rsp_out_green !== want.green) begin
               $display("%0t: green mismatch: expected %0d, actual %0d",
                        $time, want.green, rsp_out_green);
               error_count++;
            end
            if (rsp_out_red !== want.red) begin
               $display("%0t: red mismatch: expected %0d, actual %0d",
                        $time, want.red, rsp_out_red);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, expected_pixels.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The directed table walks the special cases in order. Rows whose answer is obvious carry
   // it; the rest are predicted. The comments note the statistics where they change.
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      // Straight after reset the statistics are empty, so apply passes pixels through.
      '{CMD_APPLY,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{CMD_APPLY,   '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd10,  8'd200, 8'd77},  1'b1, '{8'd10,  8'd200, 8'd77}},
      // The unused command must neither answer nor touch the statistics.
      '{CMD_UNUSED,  '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      // Black pixel: min = max = 0, so still flat.
      '{CMD_MEASURE, '{8'd0,   8'd0,   8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd10,  8'd20,  8'd30},  1'b1, '{8'd10,  8'd20,  8'd30}},
      // White pixel: min 0, max 255, full range.
      '{CMD_MEASURE, '{8'd255, 8'd255, 8'd255}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{CMD_APPLY,   '{8'd0,   8'd0,   8'd0},   1'b1, '{8'd0,   8'd0,   8'd0}},
      // Channels below three give a zero luma, which passes through.
      '{CMD_APPLY,   '{8'd1,   8'd2,   8'd1},   1'b1, '{8'd1,   8'd2,   8'd1}},
      '{CMD_APPLY,   '{8'd3,   8'd3,   8'd3},   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd255, 8'd0,   8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd0,   8'd255, 8'd128}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      // Clear, then narrow the range to lumas 90..150.
      '{CMD_CLEAR,   '{8'd170, 8'd85,  8'd51},  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_MEASURE, '{8'd90,  8'd90,  8'd90},  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_MEASURE, '{8'd150, 8'd150, 8'd150}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      // Luma 30 clamps up to the minimum, the stretch is zero, the pixel comes back as is.
      '{CMD_APPLY,   '{8'd30,  8'd30,  8'd30},  1'b1, '{8'd30,  8'd30,  8'd30}},
      // Luma 240 clamps down to the maximum.
      '{CMD_APPLY,   '{8'd240, 8'd240, 8'd240}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      // A saturated channel inside the range.
      '{CMD_APPLY,   '{8'd255, 8'd0,   8'd120}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd120, 8'd120, 8'd120}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_UNUSED,  '{8'd0,   8'd0,   8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd150, 8'd150, 8'd150}, 1'b0, '{8'd0,   8'd0,   8'd0}},
      // After a clear the statistics are empty again.
      '{CMD_CLEAR,   '{8'd0,   8'd0,   8'd0},   1'b0, '{8'd0,   8'd0,   8'd0}},
      '{CMD_APPLY,   '{8'd200, 8'd100, 8'd50},  1'b1, '{8'd200, 8'd100, 8'd50}}
   };

   initial begin
      int unsigned issued;
      int unsigned frame_lo;
      int unsigned frame_hi;
      int unsigned measures;
      int unsigned applies;
      int unsigned frames;
      rgb_type     none;

      none            = '0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_MEASURE;
      req_pixel_blue  = 8'd0;
      req_pixel_green = 8'd0;
      req_pixel_red   = 8'd0;
      rsp_ready       = 1'b0;
      stall_mode      = 0;
      stat_min        = FULL_SCALE;
      stat_max        = 8'd0;
      error_count     = 0;
      cycle_count     = 0;
      measure_count   = 0;
      apply_count     = 0;
      clear_count     = 0;
      ignored_count   = 0;
      pixel_count     = 0;
      burst_left      = 0;
      frames          = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         issue_request(directed_table[i].cmd, directed_table[i].px,
                       directed_table[i].fixed_valid, directed_table[i].fixed_px);
      end
      wait_for_drain();

      // Random frames: usually a clear, a measure pass and an apply pass, with the measured
      // pixels drawn mostly from a random window so the statistics vary from narrow to full.
      // Some frames skip the clear or the measure pass, and the odd unused command is mixed in.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         frame_lo = $urandom_range(0, 255);
         frame_hi = $urandom_range(frame_lo, 255);
         measures = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
         applies  = $urandom_range(1, 6);
         if ($urandom_range(0, 3) != 0) begin
            issue_request(CMD_CLEAR, pick_pixel(0, 255), 1'b0, none);
            issued++;
         end
         for (int m = 0; m < measures; m++) begin
            if ($urandom_range(0, 19) == 0) begin
               issue_request(CMD_UNUSED, pick_pixel(0, 255), 1'b0, none);
            end
            issue_request(CMD_MEASURE, pick_pixel(frame_lo, frame_hi), 1'b0, none);
            issued++;
         end
         for (int a = 0; a < applies; a++) begin
            if ($urandom_range(0, 19) == 0) begin
               issue_request(CMD_UNUSED, pick_pixel(0, 255), 1'b0, none);
            end
            issue_request(CMD_APPLY, pick_pixel(0, 255), 1'b0, none);
            issued++;
         end
         frames++;
         // Now and then the sender holds off until the block has answered everything.
         if (frames % 10 == 0) begin
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d random frames: %0d measure, %0d apply, %0d clear, %0d unused requests.",
               frames, measure_count, apply_count, clear_count, ignored_count);
      $display("Checked %0d returned pixels, %0d left unanswered, %0d mismatches.",
               pixel_count, expected_pixels.size(), error_count);
      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
